// ----- rtl/core/kpsef_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpsef_pkg
// Shared constants, payload types and command codes for the key matrix
// scanner with its event FIFO.
// ----------------------------------------------------------------------------
package kpsef_pkg;

    // Sizing
    localparam int FIFO_DEPTH   = 256;
    localparam int ROW_COUNT    = 7;
    localparam int COLUMN_COUNT = 5;

    // Field widths fixed by the bus format
    localparam int CMD_W     = 2;
    localparam int COL_W     = 3;
    localparam int ROWS_W    = 7;
    localparam int BYTE_W    = 8;
    localparam int LED_W     = 4;
    localparam int CNT_OUT_W = 9;
    localparam int ROW_IDX_W = 3;

    // Derived storage widths
    localparam int PTR_W     = $clog2(FIFO_DEPTH);
    localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);
    localparam int COL_IDX_W = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;

    localparam logic [ROWS_W-1:0] ROW_MASK = ROWS_W'((1 << ROW_COUNT) - 1);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_SCAN  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

    // Special bytes and write byte bits
    localparam logic [BYTE_W-1:0] CODE_RESET = 8'hFE;
    localparam logic [BYTE_W-1:0] CODE_EMPTY = 8'hFF;
    localparam int WR_IRQ_EN_BIT = 6;
    localparam int WR_RESET_BIT  = 7;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [COL_W-1:0]  column;
        logic [ROWS_W-1:0] pressed_rows;
        logic [BYTE_W-1:0] write_byte;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0]    read_data;
        logic                 irq_driven;
        logic                 irq_level;
        logic [LED_W-1:0]     led_lines;
        logic [CNT_OUT_W-1:0] fifo_count;
        logic                 events_dropped;
    } t_out_item;

    // Classified work handed from the front end to the engine
    typedef struct packed {
        logic [CMD_W-1:0]  kind;
        logic [COL_W-1:0]  column;
        logic [ROWS_W-1:0] rows;
        logic [ROWS_W-1:0] changed;
        logic [BYTE_W-1:0] write_byte;
    } t_job;

endpackage

// ----- rtl/core/kpsef_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpsef_front
// Accepts items, tracks the per-column key masks and the bus start flag,
// and turns each item into a job with its mask of changed rows.
// ----------------------------------------------------------------------------
module kpsef_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  kpsef_pkg::t_in_item i_in_item,
    input  logic              i_q_ready,
    output logic              o_q_push,
    output kpsef_pkg::t_job   o_q_job
);

    logic [kpsef_pkg::ROWS_W-1:0] r_key_masks [kpsef_pkg::COLUMN_COUNT];
    logic                         r_bus_started;

    logic                            accept;
    logic                            in_range;
    logic                            scan_live;
    logic [kpsef_pkg::COL_IDX_W-1:0] col_idx;
    logic [kpsef_pkg::ROWS_W-1:0]    rows_m;
    logic [kpsef_pkg::ROWS_W-1:0]    old_mask;

    assign o_in_ready = i_q_ready;
    assign accept     = i_in_valid && i_q_ready;
    assign o_q_push   = accept;

    // Classify the item and find changed rows
    always_comb begin
        in_range  = i_in_item.column < kpsef_pkg::COL_W'(kpsef_pkg::COLUMN_COUNT);
        col_idx   = i_in_item.column[kpsef_pkg::COL_IDX_W-1:0];
        rows_m    = i_in_item.pressed_rows & kpsef_pkg::ROW_MASK;
        old_mask  = in_range ? r_key_masks[col_idx] : '0;
        scan_live = (i_in_item.cmd == kpsef_pkg::CMD_SCAN) && r_bus_started && in_range;

        o_q_job.kind       = i_in_item.cmd;
        o_q_job.column     = i_in_item.column;
        o_q_job.rows       = rows_m;
        o_q_job.changed    = scan_live ? ((old_mask ^ rows_m) & kpsef_pkg::ROW_MASK) : '0;
        o_q_job.write_byte = i_in_item.write_byte;
    end

    // Update key masks on live scans
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < kpsef_pkg::COLUMN_COUNT; c++) begin
                r_key_masks[c] <= '0;
            end
        end else if (accept && scan_live) begin
            r_key_masks[col_idx] <= rows_m;
        end
    end

    // Latch the first bus access
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_started <= 1'b0;
        end else if (accept && (i_in_item.cmd == kpsef_pkg::CMD_WRITE ||
                                i_in_item.cmd == kpsef_pkg::CMD_READ)) begin
            r_bus_started <= 1'b1;
        end
    end

endmodule

// ----- rtl/core/kpsef_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpsef_queue
// Two-entry job queue that decouples the front end from the engine.
// ----------------------------------------------------------------------------
module kpsef_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  kpsef_pkg::t_job i_job,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_pop,
    output kpsef_pkg::t_job o_job
);

    kpsef_pkg::t_job r_slot [2];
    logic            r_wr_idx;
    logic            r_rd_idx;
    logic [1:0]      r_fill;

    logic do_push;
    logic do_pop;

    assign o_ready = (r_fill != 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_job   = r_slot[r_rd_idx];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_idx] <= i_job;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= 1'b0;
            r_rd_idx <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_idx <= ~r_wr_idx;
            end
            if (do_pop) begin
                r_rd_idx <= ~r_rd_idx;
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

endmodule

// ----- rtl/core/kpsef_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpsef_engine
// Executes jobs: pushes one key event per cycle into the event memory,
// handles bus writes and reads, and holds the result in an output register.
// ----------------------------------------------------------------------------
module kpsef_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  kpsef_pkg::t_job      i_q_job,
    output logic                 o_q_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output kpsef_pkg::t_out_item o_out_item
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_RESP = 2'd2;

    localparam logic [kpsef_pkg::CNT_W-1:0] CNT_FULL =
        kpsef_pkg::CNT_W'(kpsef_pkg::FIFO_DEPTH);
    localparam logic [kpsef_pkg::PTR_W-1:0] PTR_LAST =
        kpsef_pkg::PTR_W'(kpsef_pkg::FIFO_DEPTH - 1);

    // Event memory
    logic [kpsef_pkg::BYTE_W-1:0] mem [kpsef_pkg::FIFO_DEPTH];
    logic [kpsef_pkg::BYTE_W-1:0] r_mem_q;
    logic                         mem_we;
    logic                         mem_re;
    logic [kpsef_pkg::PTR_W-1:0]  mem_waddr;
    logic [kpsef_pkg::BYTE_W-1:0] mem_wdata;

    // Control and FIFO state
    logic [1:0]                    r_state, n_state;
    logic [kpsef_pkg::PTR_W-1:0]   r_rptr, n_rptr;
    logic [kpsef_pkg::PTR_W-1:0]   r_wptr, n_wptr;
    logic [kpsef_pkg::CNT_W-1:0]   r_count, n_count;
    logic                          r_irq_en, n_irq_en;
    logic [kpsef_pkg::LED_W-1:0]   r_led, n_led;
    logic                          r_out_valid, n_out_valid;

    // Per-job working registers
    logic [kpsef_pkg::COL_W-1:0]   r_col, n_col;
    logic [kpsef_pkg::ROWS_W-1:0]  r_rows, n_rows;
    logic [kpsef_pkg::ROWS_W-1:0]  r_pending, n_pending;
    logic                          r_dropped, n_dropped;
    logic [kpsef_pkg::BYTE_W-1:0]  r_rd_data, n_rd_data;
    logic                          r_rd_mem, n_rd_mem;
    kpsef_pkg::t_out_item          r_out, n_out;

    logic [kpsef_pkg::ROW_IDX_W-1:0] row_sel;
    logic                            press;
    logic [kpsef_pkg::BYTE_W-1:0]    ev_code;
    logic                            slot_free;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Pick the lowest pending row and build its event code
    always_comb begin
        row_sel = '0;
        for (int r = kpsef_pkg::ROW_COUNT - 1; r >= 0; r--) begin
            if (r_pending[r]) begin
                row_sel = kpsef_pkg::ROW_IDX_W'(r);
            end
        end
        press   = r_rows[row_sel];
        ev_code = {!press, press, row_sel + 3'd1, r_col + 3'd1};
    end

    // Sequence jobs
    always_comb begin
        n_state     = r_state;
        n_rptr      = r_rptr;
        n_wptr      = r_wptr;
        n_count     = r_count;
        n_irq_en    = r_irq_en;
        n_led       = r_led;
        n_col       = r_col;
        n_rows      = r_rows;
        n_pending   = r_pending;
        n_dropped   = r_dropped;
        n_rd_data   = r_rd_data;
        n_rd_mem    = r_rd_mem;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        o_q_pop     = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = r_wptr;
        mem_wdata   = ev_code;

        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop   = 1'b1;
                    n_dropped = 1'b0;
                    n_rd_data = '0;
                    n_rd_mem  = 1'b0;
                    n_state   = ST_RESP;
                    unique case (i_q_job.kind)
                        kpsef_pkg::CMD_SCAN: begin
                            n_col     = i_q_job.column;
                            n_rows    = i_q_job.rows;
                            n_pending = i_q_job.changed;
                            if (i_q_job.changed != '0) begin
                                n_state = ST_SCAN;
                            end
                        end
                        kpsef_pkg::CMD_WRITE: begin
                            n_irq_en = i_q_job.write_byte[kpsef_pkg::WR_IRQ_EN_BIT];
                            n_led    = i_q_job.write_byte[kpsef_pkg::LED_W-1:0];
                            if (i_q_job.write_byte[kpsef_pkg::WR_RESET_BIT]) begin
                                mem_we    = 1'b1;
                                mem_waddr = '0;
                                mem_wdata = kpsef_pkg::CODE_RESET;
                                n_rptr    = '0;
                                n_wptr    = kpsef_pkg::PTR_W'(1);
                                n_count   = kpsef_pkg::CNT_W'(1);
                            end
                        end
                        kpsef_pkg::CMD_READ: begin
                            if (r_count != '0) begin
                                mem_re   = 1'b1;
                                n_rd_mem = 1'b1;
                                n_rptr   = (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
                                n_count  = r_count - 1'b1;
                            end else begin
                                n_rd_data = kpsef_pkg::CODE_EMPTY;
                            end
                        end
                        kpsef_pkg::CMD_NOP: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // Push one event per cycle, drop it when full
                if (r_count != CNT_FULL) begin
                    mem_we  = 1'b1;
                    n_wptr  = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
                    n_count = r_count + 1'b1;
                end else begin
                    n_dropped = 1'b1;
                end
                n_pending = r_pending & ~(kpsef_pkg::ROWS_W'(1) << row_sel);
                if (n_pending == '0) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (slot_free) begin
                    n_out.read_data      = r_rd_mem ? r_mem_q : r_rd_data;
                    n_out.irq_driven     = r_irq_en;
                    n_out.irq_level      = !(r_irq_en && (r_count != '0));
                    n_out.led_lines      = r_led;
                    n_out.fifo_count     = kpsef_pkg::CNT_OUT_W'(r_count);
                    n_out.events_dropped = r_dropped;
                    n_out_valid          = 1'b1;
                    n_state              = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Event memory port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mem_q <= mem[r_rptr];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rptr      <= '0;
            r_wptr      <= '0;
            r_count     <= '0;
            r_irq_en    <= 1'b0;
            r_led       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rptr      <= n_rptr;
            r_wptr      <= n_wptr;
            r_count     <= n_count;
            r_irq_en    <= n_irq_en;
            r_led       <= n_led;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and payload registers
    always_ff @(posedge i_clk) begin
        r_col     <= n_col;
        r_rows    <= n_rows;
        r_pending <= n_pending;
        r_dropped <= n_dropped;
        r_rd_data <= n_rd_data;
        r_rd_mem  <= n_rd_mem;
        r_out     <= n_out;
    end

endmodule

// ----- rtl/core/keypad_scanner_event_fifo.sv -----
`timescale 1ns / 1ps
// Flow: an accepted item waits in the two-entry job queue; the engine takes
//   one job at a time, spends one scan step per changed row, then registers
//   the result in its response state, which waits while the output is
//   stalled; only then does the engine take the next job.
// Reset: synchronous, active low; clears key masks, pointers, count, LED and
//   interrupt latches; the event memory is not cleared.
// ----------------------------------------------------------------------------
// keypad_scanner_event_fifo
// Key matrix scanner with a byte-wide event FIFO: a front end classifies
// items, a job queue decouples it from the engine that fills the FIFO.
// ----------------------------------------------------------------------------
module keypad_scanner_event_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  kpsef_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output kpsef_pkg::t_out_item o_out_item
);

    logic            q_ready;
    logic            q_push;
    logic            q_valid;
    logic            q_pop;
    kpsef_pkg::t_job push_job;
    kpsef_pkg::t_job pop_job;

    // Classify incoming items
    kpsef_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_q_ready  (q_ready),
        .o_q_push   (q_push),
        .o_q_job    (push_job)
    );

    // Hold jobs between the two sides
    kpsef_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_job   (pop_job)
    );

    // Carry out jobs against the event FIFO
    kpsef_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_job     (pop_job),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// ----- rtl/core/kpsef_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpsef_checker
// Port-level checks for the key matrix scanner, bound to the top level.
// ----------------------------------------------------------------------------
module kpsef_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input kpsef_pkg::t_in_item  i_in_item,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input kpsef_pkg::t_out_item o_out_item
);

    // Hold an offered item until it is taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_item))
        else $error("input item changed while waiting");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // Release the output after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // Drive the line low only while enabled
    a_irq_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.irq_driven || o_out_item.irq_level)
        else $error("interrupt level low while not driven");

    // Drop events only into a full FIFO
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.events_dropped |->
            o_out_item.fifo_count == kpsef_pkg::CNT_OUT_W'(kpsef_pkg::FIFO_DEPTH))
        else $error("event dropped while FIFO not full");

endmodule

bind keypad_scanner_event_fifo kpsef_checker u_kpsef_checker (.*);
